// File: sv/clrs_pkg.sv
// Shared types, codes and constant tables of the character LCD refresh sequencer.
`timescale 1ns / 1ps
package clrs_pkg;

  localparam int LINE_WIDTH_DEF = 16;

  localparam logic [7:0]  PHASE_TICKS_RST = 8'd3;
  localparam logic [23:0] POWER_UP_RST    = 24'd50000;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CMD_LINE1   = 8'h80;
  localparam logic [7:0] CMD_LINE2   = 8'hC0;
  localparam logic [7:0] CMD_CGRAM   = 8'h40;

  typedef enum logic [0:0] {
    CFG_PHASE_TICKS = 1'b0,
    CFG_POWER_UP    = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_INIT    = 3'd2,
    KIND_REFRESH = 3'd3,
    KIND_GLYPH   = 3'd4,
    KIND_CLEAR   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_WRITE,
    OP_START,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_INIT,
    MODE_REFRESH,
    MODE_GLYPH
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POWER,
    PH_SETUP,
    PH_EHI,
    PH_ELO,
    PH_RELEASE,
    PH_POLLHI,
    PH_POLLLO
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       busy_pin;
    logic [4:0] position;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic       enable_line;
    logic       select_line;
    logic       read_line;
    logic [7:0] bus_value;
    logic       bus_drive;
    logic       sequencer_busy;
    logic       accepted;
  } out_item_t;

  // classified request as held in the queue between front and back
  typedef struct packed {
    op_t        op;
    mode_t      mode;
    logic       busy_pin;
    logic [4:0] position;
    logic [7:0] char_code;
  } q_item_t;

  typedef struct packed {
    logic       e;
    logic       rs;
    logic       rw;
    logic [7:0] bus;
    logic       drive;
  } pins_t;

  // power-on command list: function set, display on, clear, home, entry mode
  function automatic logic [7:0] init_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = 8'h38;
      3'd1:    b = 8'h0E;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h02;
      3'd4:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // eight CGRAM rows of the custom glyph
  function automatic logic [7:0] glyph_row(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd1:    b = 8'h0A;
      3'd2:    b = 8'h15;
      3'd3:    b = 8'h11;
      3'd4:    b = 8'h0A;
      3'd5:    b = 8'h04;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: sv/clrs_if.sv
// Valid/ready channel carrying one payload of type T.
`timescale 1ns / 1ps
interface clrs_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/clrs_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module clrs_front (
  input  logic              clk,
  input  logic              rst_n,
  clrs_if.sink              in_chan,
  output clrs_pkg::q_item_t head,
  output logic              head_valid,
  input  logic              pop
);
  import clrs_pkg::*;

  q_item_t    q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  q_item_t    cls;

  always_comb begin
    cls.busy_pin  = in_chan.data.busy_pin;
    cls.position  = in_chan.data.position;
    cls.char_code = in_chan.data.char_code;
    cls.mode      = MODE_IDLE;
    case (kind_t'(in_chan.data.kind))
      KIND_TICK:    cls.op = OP_TICK;
      KIND_WRITE:   cls.op = OP_WRITE;
      KIND_INIT:    begin cls.op = OP_START; cls.mode = MODE_INIT;    end
      KIND_REFRESH: begin cls.op = OP_START; cls.mode = MODE_REFRESH; end
      KIND_GLYPH:   begin cls.op = OP_START; cls.mode = MODE_GLYPH;   end
      KIND_CLEAR:   cls.op = OP_CLEAR;
      default:      cls.op = OP_NOP;
    endcase
  end

  assign in_chan.ready = (count_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign head          = q_r[rptr_r];
  assign head_valid    = (count_r != 2'd0);

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wptr_r] <= cls;
  end

endmodule

// File: sv/clrs_back.sv
// Back end: frame store, byte sequencer, bus phase timing and result register.
`timescale 1ns / 1ps
module clrs_back #(
  parameter int LINE_WIDTH = clrs_pkg::LINE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  clrs_pkg::cfg_idx_t cfg_index,
  input  logic [23:0]        cfg_wdata,
  input  clrs_pkg::q_item_t  head,
  input  logic               head_valid,
  output logic               pop,
  clrs_if.source             out_chan
);
  import clrs_pkg::*;

  localparam int Depth = 2 * LINE_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam int IW    = $clog2(2 * LINE_WIDTH + 3);
  localparam logic [IW-1:0] LenInit    = IW'(5);
  localparam logic [IW-1:0] LenGlyph   = IW'(9);
  localparam logic [IW-1:0] LenRefresh = IW'(2 * LINE_WIDTH + 2);
  localparam logic [IW-1:0] Row1End    = IW'(LINE_WIDTH);
  localparam logic [IW-1:0] Row2Cmd    = IW'(LINE_WIDTH + 1);
  localparam logic [6:0]    DepthW     = 7'(Depth);

  // configuration
  logic [7:0]  phase_ticks_r;
  logic [23:0] power_up_r;
  logic [23:0] tpp;

  // sequencer state
  mode_t         mode_r, mode_nxt;
  phase_t        phase_r, phase_nxt;
  logic [IW-1:0] idx_r, idx_nxt, idx_inc;
  logic [23:0]   wait_r, wait_nxt;
  logic          seen_r, seen_nxt;
  pins_t         pins_r, pins_nxt;

  // frame store
  logic [7:0]    store_mem [Depth];
  logic [Depth-1:0] vld_r;
  logic [7:0]    rd_data_r;
  logic          rd_vld_r;
  logic          clr_r, byp_r;
  logic [7:0]    byp_data_r;
  logic [AW-1:0] rd_addr_nxt, wr_addr;
  logic          rd_vld_nxt;
  logic [7:0]    cur_char;
  logic          wr_now, clear_now;

  // current byte
  logic [7:0]    cur_byte;
  logic          cur_rs;
  logic [IW-1:0] seq_len;
  logic          accepted;

  logic          out_valid_r;
  out_item_t     out_data_r;

  assign tpp = (phase_ticks_r == 8'd0) ? 24'd1 : 24'(phase_ticks_r);
  assign pop = head_valid && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      power_up_r    <= POWER_UP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_TICKS: phase_ticks_r <= cfg_wdata[7:0];
        CFG_POWER_UP:    power_up_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // store entry at the current byte, with same-cycle write and clear forwarded
  assign cur_char = clr_r ? CHAR_SPACE :
                    byp_r ? byp_data_r :
                    rd_vld_r ? rd_data_r : CHAR_SPACE;

  always_comb begin
    cur_rs   = 1'b0;
    cur_byte = 8'h00;
    seq_len  = '0;
    case (mode_r)
      MODE_INIT: begin
        seq_len  = LenInit;
        cur_byte = (idx_r < LenInit) ? init_byte(idx_r[2:0]) : 8'h00;
      end
      MODE_GLYPH: begin
        seq_len = LenGlyph;
        if (idx_r == '0) begin
          cur_byte = CMD_CGRAM;
        end else begin
          cur_rs   = 1'b1;
          cur_byte = (idx_r <= IW'(8)) ? glyph_row(3'(idx_r - IW'(1))) : 8'h00;
        end
      end
      MODE_REFRESH: begin
        seq_len = LenRefresh;
        if (idx_r == '0) begin
          cur_byte = CMD_LINE1;
        end else if (idx_r <= Row1End) begin
          cur_rs   = 1'b1;
          cur_byte = cur_char;
        end else if (idx_r == Row2Cmd) begin
          cur_byte = CMD_LINE2;
        end else if (idx_r < LenRefresh) begin
          cur_rs   = 1'b1;
          cur_byte = cur_char;
        end
      end
      default: ;
    endcase
  end

  assign idx_inc = idx_r + IW'(1);

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    wait_nxt  = wait_r;
    seen_nxt  = seen_r;
    pins_nxt  = pins_r;
    accepted  = 1'b1;
    clear_now = 1'b0;
    wr_now    = 1'b0;
    if (pop) begin
      case (head.op)
        OP_TICK: begin
          if (mode_r != MODE_IDLE && phase_r != PH_IDLE) begin
            case (phase_r)
              PH_POWER:   pins_nxt = '{1'b0, 1'b0, 1'b0, 8'h00, 1'b1};
              PH_SETUP:   pins_nxt = '{1'b0, cur_rs, 1'b0, cur_byte, 1'b1};
              PH_EHI:     pins_nxt = '{1'b1, cur_rs, 1'b0, cur_byte, 1'b1};
              PH_ELO:     pins_nxt = '{1'b0, cur_rs, 1'b0, cur_byte, 1'b1};
              PH_POLLHI:  pins_nxt = '{1'b1, 1'b0, 1'b1, 8'h00, 1'b0};
              default:    pins_nxt = '{1'b0, 1'b0, 1'b1, 8'h00, 1'b0};
            endcase
            if (phase_r == PH_POLLHI && wait_r <= 24'd1) seen_nxt = head.busy_pin;
            if (wait_r > 24'd1) begin
              wait_nxt = wait_r - 24'd1;
            end else begin
              wait_nxt = 24'd0;
              case (phase_r)
                PH_POWER:   begin phase_nxt = PH_SETUP;   wait_nxt = tpp; end
                PH_SETUP:   begin phase_nxt = PH_EHI;     wait_nxt = tpp; end
                PH_EHI:     begin phase_nxt = PH_ELO;     wait_nxt = tpp; end
                PH_ELO:     begin phase_nxt = PH_RELEASE; wait_nxt = tpp; end
                PH_RELEASE: begin phase_nxt = PH_POLLHI;  wait_nxt = tpp; end
                PH_POLLHI:  begin phase_nxt = PH_POLLLO;  wait_nxt = tpp; end
                default: begin
                  if (seen_r) begin
                    phase_nxt = PH_POLLHI;
                    wait_nxt  = tpp;
                  end else begin
                    // byte done: restore the bus, move on or finish
                    pins_nxt = '{1'b0, 1'b0, 1'b0, 8'h00, 1'b1};
                    if (idx_inc >= seq_len) begin
                      clear_now = (mode_r == MODE_INIT);
                      mode_nxt  = MODE_IDLE;
                      phase_nxt = PH_IDLE;
                      idx_nxt   = '0;
                    end else begin
                      idx_nxt   = idx_inc;
                      phase_nxt = PH_SETUP;
                      wait_nxt  = tpp;
                    end
                  end
                end
              endcase
            end
          end
        end
        OP_WRITE: wr_now = (7'(head.position) < DepthW);
        OP_START: begin
          if (mode_r != MODE_IDLE) begin
            accepted = 1'b0;
          end else begin
            idx_nxt  = '0;
            seen_nxt = 1'b0;
            mode_nxt = head.mode;
            if (head.mode == MODE_INIT && power_up_r != 24'd0) begin
              phase_nxt = PH_POWER;
              wait_nxt  = power_up_r;
            end else begin
              phase_nxt = PH_SETUP;
              wait_nxt  = tpp;
            end
          end
        end
        OP_CLEAR: clear_now = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      wait_r  <= 24'd0;
      seen_r  <= 1'b0;
      pins_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      wait_r  <= wait_nxt;
      seen_r  <= seen_nxt;
      pins_r  <= pins_nxt;
    end
  end

  // store address of the byte the sequencer will point at next cycle
  assign rd_addr_nxt = (idx_nxt <= Row1End) ? AW'(idx_nxt - IW'(1)) : AW'(idx_nxt - IW'(2));
  assign rd_vld_nxt  = (7'(rd_addr_nxt) < DepthW) ? vld_r[rd_addr_nxt] : 1'b0;
  assign wr_addr     = AW'(head.position);

  always_ff @(posedge clk) begin
    if (wr_now) store_mem[wr_addr] <= head.char_code;
    rd_data_r  <= store_mem[rd_addr_nxt];
    byp_data_r <= head.char_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      clr_r    <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (clear_now)   vld_r          <= '0;
      else if (wr_now) vld_r[wr_addr] <= 1'b1;
      rd_vld_r <= rd_vld_nxt;
      clr_r    <= clear_now;
      byp_r    <= wr_now && (wr_addr == rd_addr_nxt);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.enable_line    <= pins_nxt.e;
      out_data_r.select_line    <= pins_nxt.rs;
      out_data_r.read_line      <= pins_nxt.rw;
      out_data_r.bus_value      <= pins_nxt.bus;
      out_data_r.bus_drive      <= pins_nxt.drive;
      out_data_r.sequencer_busy <= (mode_nxt != MODE_IDLE);
      out_data_r.accepted       <= accepted;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

// File: sv/char_lcd_refresh_sequencer.sv
// Top level of the HD44780-style 8-bit character LCD refresh sequencer.
// Requests are queued, then popped into the result register that drives out_chan.
// Throughput: one request per cycle, one retired a cycle, unless out_chan stalls.
// Two-entry queue between front and back; the result register frees on out_chan.ready.
// Reset: synchronous, active low; sequencer idle, pins low with the bus released,
// frame store reads as spaces at once through per-entry valid bits (no clearing pass).
`timescale 1ns / 1ps
module char_lcd_refresh_sequencer #(
  parameter int LINE_WIDTH = clrs_pkg::LINE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  clrs_if.sink               in_chan,
  clrs_if.source             out_chan,
  input  logic               cfg_we,
  input  clrs_pkg::cfg_idx_t cfg_index,
  input  logic [23:0]        cfg_wdata
);
  import clrs_pkg::*;

  // classified request at the head of the queue
  q_item_t head;
  logic    head_valid;
  logic    pop;

  // front: decode kind into an operation and buffer up to two requests
  clrs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // back: frame store, byte sequencer with E/busy-poll phases, result register.
  // Only tick requests advance pin timing; other requests report the held pins.
  clrs_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule
